// File: rtl/core/lsfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsfba_pkg;

  // Default sizing of the usage store
  localparam int MAX_SEGMENTS_DEF           = 64;
  localparam int MAX_BLOCKS_PER_SEGMENT_DEF = 64;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int SEG_W     = 6;
  localparam int BLK_W     = 6;
  localparam int CNT_W     = 13;
  localparam int BPS_W     = 7;
  localparam int SEGCNT_W  = 7;
  localparam int SUMM_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NEXT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGCNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUMMARY = 2'd2;

  // Register reset values
  localparam logic [BPS_W-1:0]    BPS_RST    = 7'd64;
  localparam logic [SEGCNT_W-1:0] SEGCNT_RST = 7'd64;
  localparam logic [SUMM_W-1:0]   SUMM_RST   = 6'd1;

  // Usage bit values
  localparam logic USAGE_INUSE = 1'b1;
  localparam logic USAGE_FREE  = 1'b0;

  // One result
  typedef struct packed {
    logic             accepted;
    logic [SEG_W-1:0] next_segment;
    logic [BLK_W-1:0] next_block;
    logic             full_res;
    logic [CNT_W-1:0] used_count;
  } result_t;

  // Status of the bit count pipeline
  typedef struct packed {
    logic pending;
    logic done;
  } cnt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lsfba_usage_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lsfba_usage_mem #(
  parameter int DEPTH = lsfba_pkg::MAX_SEGMENTS_DEF,
  parameter int WIDTH = lsfba_pkg::MAX_BLOCKS_PER_SEGMENT_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/lsfba_bit_count.sv
`timescale 1ns / 1ps
`default_nettype none

module lsfba_bit_count #(
  parameter int WIDTH = lsfba_pkg::MAX_BLOCKS_PER_SEGMENT_DEF,
  localparam int CW   = $clog2(WIDTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  input  wire logic [WIDTH-1:0]     word,
  output lsfba_pkg::cnt_stat_t      stat,
  output logic      [CW-1:0]        count
);

  localparam int NG = (WIDTH + 7) / 8;

  logic [NG*8-1:0] padded;
  logic [3:0]      grp_nxt [NG];
  logic [3:0]      grp_r   [NG];
  logic            a_vld_r;
  logic [CW-1:0]   sum_nxt;
  logic [CW-1:0]   sum_r;
  logic            b_vld_r;

  assign padded = (NG*8)'(word);

  // Count each byte lane
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        grp_nxt[g] = grp_nxt[g] + 4'(padded[g*8+j]);
      end
    end
  end

  // Add the lane counts
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + CW'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    sum_r <= sum_nxt;
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  assign stat.pending = a_vld_r;
  assign stat.done    = b_vld_r;
  assign count        = sum_r;

endmodule

`default_nettype wire

// File: rtl/core/log_segment_free_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Log segment free-block allocator.
// A request is taken at a rising edge with start high and busy low. Its one
// result is shown on the out_ ports for a single cycle with out_valid high;
// the receiver cannot stall, so results are never held back.
// Configuration writes use cfg_valid/cfg_ready (always ready), index 0 blocks
// per segment, 1 segment count, 2 summary blocks; write only while idle.
// How each request reaches out_valid:
//   unknown request, or next free inside the segment: shown in the cycle after accept.
//   set usage: one read-modify-write of the usage word, then the result.
//   next free at segment end: segments are read in turn until one is found free;
//   at most segment count - 1 segments are read, one word a cycle through
//   the usage memory read port.
//   count used: segment count words are read, one word a cycle through the
//   read port, then a two-stage bit count and the sum.
// busy stays high while a set, segment-end search or count request runs; the next request may be
// taken in the cycle its result is shown.
// After reset a clearing pass writes MAX_SEGMENTS words to free, one a cycle,
// with busy high; configuration writes are taken during it.
module log_segment_free_block_allocator_unit #(
  parameter int MAX_SEGMENTS           = lsfba_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_BLOCKS_PER_SEGMENT = lsfba_pkg::MAX_BLOCKS_PER_SEGMENT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lsfba_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [lsfba_pkg::SEG_W-1:0]     in_segment,
  input  wire logic [lsfba_pkg::BLK_W-1:0]     in_block,
  input  wire logic                            in_in_use,
  output logic                                 out_valid,
  output logic                                 out_accepted,
  output logic      [lsfba_pkg::SEG_W-1:0]     out_next_segment,
  output logic      [lsfba_pkg::BLK_W-1:0]     out_next_block,
  output logic                                 out_full_res,
  output logic      [lsfba_pkg::CNT_W-1:0]     out_used_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lsfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsfba_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int BW   = MAX_BLOCKS_PER_SEGMENT;
  localparam int AW   = $clog2(MAX_SEGMENTS);
  localparam int BIW  = $clog2(BW);
  localparam int PCW  = $clog2(BW + 1);
  localparam int SC_CAP = (MAX_SEGMENTS > 127) ? 127 : MAX_SEGMENTS;
  localparam logic [6:0]    SC_CAP_W = 7'(SC_CAP);
  localparam logic [6:0]    BW_W     = 7'(BW);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SEGMENTS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SET    = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_COUNT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [lsfba_pkg::BPS_W-1:0]    bps_r;
  logic [lsfba_pkg::SEGCNT_W-1:0] segcnt_r;
  logic [lsfba_pkg::SUMM_W-1:0]   summ_r;

  logic [AW-1:0]  clr_r;
  logic           wr_ok_r;
  logic           seg_nz_r;
  logic           use_r;
  logic [BIW-1:0] bit_r;
  logic [AW-1:0]  set_addr_r;

  logic [6:0]     start_r;
  logic [6:0]     f_r;
  logic [6:0]     left_r;
  logic [6:0]     s_r;
  logic           rd_vld_r;
  logic [6:0]     rd_seg_r;
  logic           rd_inr_r;
  logic [lsfba_pkg::CNT_W-1:0] acc_r;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  lsfba_pkg::result_t    res_r;
  lsfba_pkg::result_t    res_nxt;

  logic [6:0]     bps_eff;
  logic [6:0]     sc_eff;
  logic [BW-1:0]  cnt_mask;
  logic [BW-1:0]  chk_mask;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [BW-1:0]  rd_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [BW-1:0]  wr_data;

  logic           accept;
  logic [6:0]     cur;
  logic [6:0]     cur_inc;
  logic [6:0]     f_init;
  logic [6:0]     left_init;
  logic [6:0]     f_inc;
  logic [6:0]     f_next;
  logic           issue_srch;
  logic           issue_cnt;
  logic           found;

  lsfba_pkg::cnt_stat_t cnt_stat;
  logic [PCW-1:0]       cnt_val;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the configured sizes to the store
  assign bps_eff = (bps_r > BW_W) ? BW_W : bps_r;
  assign sc_eff  = (segcnt_r > SC_CAP_W) ? SC_CAP_W : segcnt_r;

  // Build the count and free-check masks
  always_comb begin
    for (int i = 0; i < BW; i++) begin
      cnt_mask[i] = (7'(i) < bps_eff);
      chk_mask[i] = cnt_mask[i] && (6'(i) >= summ_r);
    end
  end

  // Search start and step
  assign cur       = (in_segment == '0) ? 7'd1 : 7'(in_segment);
  assign cur_inc   = cur + 7'd1;
  assign f_init    = (cur_inc >= sc_eff) ? 7'd1 : cur_inc;
  assign left_init = (sc_eff > 7'd1) ? (sc_eff - 7'd1) : 7'd0;
  assign f_inc     = f_r + 7'd1;
  assign f_next    = (f_inc >= sc_eff) ? 7'd1 : f_inc;
  assign issue_srch = (left_r != 7'd0) && (f_r != start_r);
  assign issue_cnt  = (s_r < sc_eff);
  assign found      = rd_vld_r && rd_inr_r && ((rd_data & chk_mask) == '0);

  // Drive the usage memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_en   = accept && (in_req_type == lsfba_pkg::REQ_SET);
        rd_addr = AW'(in_segment);
      end
      ST_SET: begin
        wr_en          = wr_ok_r;
        wr_addr        = set_addr_r;
        wr_data[bit_r] = use_r;
      end
      ST_SEARCH: begin
        rd_en   = issue_srch && !found;
        rd_addr = AW'(f_r);
      end
      ST_COUNT: begin
        rd_en   = issue_cnt;
        rd_addr = AW'(s_r);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  lsfba_usage_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (BW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lsfba_bit_count #(
    .WIDTH (BW)
  ) u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r && (state_r == ST_COUNT)),
    .word   (rd_data & cnt_mask),
    .stat   (cnt_stat),
    .count  (cnt_val)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            lsfba_pkg::REQ_SET:   state_nxt = ST_SET;
            lsfba_pkg::REQ_NEXT: begin
              if ((7'(in_block) + 7'd1) >= bps_eff) state_nxt = ST_SEARCH;
            end
            lsfba_pkg::REQ_COUNT: state_nxt = ST_COUNT;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SET: begin
        state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (found || (!issue_srch && !rd_vld_r)) state_nxt = ST_IDLE;
      end
      ST_COUNT: begin
        if (!issue_cnt && !rd_vld_r && !cnt_stat.pending && !cnt_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Build the result shown in the next cycle
  always_comb begin
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    unique case (state_r)
      ST_CLEAR: begin
      end
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          unique case (in_req_type)
            lsfba_pkg::REQ_SET: begin
            end
            lsfba_pkg::REQ_NEXT: begin
              res_nxt.next_segment = cur[lsfba_pkg::SEG_W-1:0];
              res_nxt.next_block   = in_block + lsfba_pkg::BLK_W'(1);
              out_valid_nxt        = ((7'(in_block) + 7'd1) < bps_eff);
            end
            lsfba_pkg::REQ_COUNT: begin
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SET: begin
        res_nxt          = '0;
        res_nxt.accepted = seg_nz_r;
        out_valid_nxt    = 1'b1;
      end
      ST_SEARCH: begin
        if (found) begin
          res_nxt              = '0;
          res_nxt.next_segment = rd_seg_r[lsfba_pkg::SEG_W-1:0];
          res_nxt.next_block   = summ_r;
          out_valid_nxt        = 1'b1;
        end else if (!issue_srch && !rd_vld_r) begin
          res_nxt              = '0;
          res_nxt.next_segment = start_r[lsfba_pkg::SEG_W-1:0];
          res_nxt.next_block   = summ_r;
          res_nxt.full_res     = 1'b1;
          out_valid_nxt        = 1'b1;
        end
      end
      ST_COUNT: begin
        if (!issue_cnt && !rd_vld_r && !cnt_stat.pending && !cnt_stat.done) begin
          res_nxt            = '0;
          res_nxt.used_count = acc_r;
          out_valid_nxt      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      bps_r       <= lsfba_pkg::BPS_RST;
      segcnt_r    <= lsfba_pkg::SEGCNT_RST;
      summ_r      <= lsfba_pkg::SUMM_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Take a configuration write
      if (cfg_valid) begin
        case (cfg_index)
          lsfba_pkg::CFG_BPS:     bps_r    <= cfg_data;
          lsfba_pkg::CFG_SEGCNT:  segcnt_r <= cfg_data;
          lsfba_pkg::CFG_SUMMARY: summ_r   <= cfg_data[lsfba_pkg::SUMM_W-1:0];
          default:                bps_r    <= bps_r;
        endcase
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
        end
        ST_IDLE: begin
          rd_vld_r <= 1'b0;
        end
        ST_SET: begin
        end
        ST_SEARCH: begin
          if (found) begin
            rd_vld_r <= 1'b0;
          end else if (issue_srch) begin
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
        end
        ST_COUNT: begin
          rd_vld_r <= issue_cnt;
        end
        default: begin
          rd_vld_r <= 1'b0;
        end
      endcase
    end
  end

  // Hold the result until the next one
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Request payload and walk registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CLEAR: begin
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            lsfba_pkg::REQ_SET: begin
              seg_nz_r   <= (in_segment != '0);
              wr_ok_r    <= (in_segment != '0) && (32'(in_segment) < MAX_SEGMENTS) &&
                            (32'(in_block) < BW);
              use_r      <= in_in_use ? lsfba_pkg::USAGE_INUSE : lsfba_pkg::USAGE_FREE;
              bit_r      <= BIW'(in_block);
              set_addr_r <= AW'(in_segment);
            end
            lsfba_pkg::REQ_NEXT: begin
              start_r <= cur;
              f_r     <= f_init;
              left_r  <= left_init;
            end
            lsfba_pkg::REQ_COUNT: begin
              s_r   <= '0;
              acc_r <= '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SET: begin
      end
      ST_SEARCH: begin
        if (!found && issue_srch) begin
          rd_seg_r <= f_r;
          rd_inr_r <= (32'(f_r) < MAX_SEGMENTS);
          f_r      <= f_next;
          left_r   <= left_r - 7'd1;
        end
      end
      ST_COUNT: begin
        if (issue_cnt) begin
          s_r <= s_r + 7'd1;
        end
        if (cnt_stat.done) begin
          acc_r <= acc_r + lsfba_pkg::CNT_W'(cnt_val);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = res_r.accepted;
  assign out_next_segment = res_r.next_segment;
  assign out_next_block   = res_r.next_block;
  assign out_full_res     = res_r.full_res;
  assign out_used_count   = res_r.used_count;

endmodule

`default_nettype wire

// File: verif/log_segment_free_block_allocator_checker.sv
`timescale 1ns / 1ps

module log_segment_free_block_allocator_checker
  import lsfba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [SEG_W-1:0]     in_segment,
  input  logic [BLK_W-1:0]     in_block,
  input  logic                 in_in_use,
  input  logic                 out_valid,
  input  logic                 out_accepted,
  input  logic [SEG_W-1:0]     out_next_segment,
  input  logic [BLK_W-1:0]     out_next_block,
  input  logic                 out_full_res,
  input  logic [CNT_W-1:0]     out_used_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   replies_due
);

  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam int NBLK = MAX_BLOCKS_PER_SEGMENT_DEF;

  // Shadow copy of the usage store and the registers
  logic [NBLK-1:0]     shadow_map [NSEG];
  logic [BPS_W-1:0]    blocks_per_seg;
  logic [SEGCNT_W-1:0] seg_total;
  logic [SUMM_W-1:0]   summary_len;
  result_t             alloc_replies[$];

  initial begin
    fail_count  = 0;
    replies_due = 0;
  end

  function automatic int usable_blocks();
    return (blocks_per_seg > NBLK) ? NBLK : int'(blocks_per_seg);
  endfunction

  function automatic int usable_segments();
    return (seg_total > NSEG) ? NSEG : int'(seg_total);
  endfunction

  function automatic logic [NBLK-1:0] low_ones(int n);
    if (n >= NBLK)
      return '1;
    return ({{(NBLK-1){1'b0}}, 1'b1} << n) - 1'b1;
  endfunction

  // Walk forward from the head segment, wrapping to segment 1, for a segment
  // whose blocks past the summary area are all free
  function automatic bit find_open_segment(int head, output int hit);
    int              total;
    int              left;
    int              f;
    logic [NBLK-1:0] chk;
    total = usable_segments();
    chk   = low_ones(usable_blocks()) & ~low_ones(int'(summary_len));
    left  = (total > 1) ? total - 1 : 0;
    f     = head + 1;
    hit   = 0;
    if (f >= total)
      f = 1;
    while (left > 0 && f != head) begin
      if (f < NSEG && (shadow_map[f] & chk) == '0) begin
        hit = f;
        return 1'b1;
      end
      f = (f + 1 >= total) ? 1 : f + 1;
      left--;
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow store and return its reply
  function automatic result_t compute_alloc_reply(logic [REQ_W-1:0] req, logic [SEG_W-1:0] seg,
                                                  logic [BLK_W-1:0] blk, logic mark);
    result_t         r;
    int              head;
    int              hit;
    int              tally;
    logic [NBLK-1:0] mask;
    r = '0;
    case (req)
      REQ_SET: begin
        if (seg != 0) begin
          r.accepted = 1'b1;
          shadow_map[seg][blk] = mark ? USAGE_INUSE : USAGE_FREE;
        end
      end
      REQ_NEXT: begin
        head = (seg == 0) ? 1 : int'(seg);
        if (int'(blk) + 1 >= usable_blocks()) begin
          r.next_block = summary_len;
          if (find_open_segment(head, hit)) begin
            r.next_segment = hit[SEG_W-1:0];
          end else begin
            r.next_segment = head[SEG_W-1:0];
            r.full_res     = 1'b1;
          end
        end else begin
          r.next_segment = head[SEG_W-1:0];
          r.next_block   = blk + 1'b1;
        end
      end
      REQ_COUNT: begin
        mask  = low_ones(usable_blocks());
        tally = 0;
        for (int s = 0; s < usable_segments(); s++)
          tally += $countones(shadow_map[s] & mask);
        r.used_count = tally[CNT_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      for (int s = 0; s < NSEG; s++)
        shadow_map[s] = '0;
      blocks_per_seg = BPS_RST;
      seg_total      = SEGCNT_RST;
      summary_len    = SUMM_RST;
      alloc_replies.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BPS:     blocks_per_seg = cfg_data[BPS_W-1:0];
          CFG_SEGCNT:  seg_total      = cfg_data[SEGCNT_W-1:0];
          CFG_SUMMARY: summary_len    = cfg_data[SUMM_W-1:0];
          default: ;
        endcase
      end

      // Compare the shown reply with the oldest prediction
      if (out_valid) begin
        got = '{out_accepted, out_next_segment, out_next_block, out_full_res, out_used_count};
        if (alloc_replies.size() == 0) begin
          $error("unexpected reply: no request outstanding");
          fail_count++;
        end else begin
          want = alloc_replies.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count++;
          end
          if (got.next_segment !== want.next_segment) begin
            $error("next_segment: expected %0d, got %0d", want.next_segment, got.next_segment);
            fail_count++;
          end
          if (got.next_block !== want.next_block) begin
            $error("next_block: expected %0d, got %0d", want.next_block, got.next_block);
            fail_count++;
          end
          if (got.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
            fail_count++;
          end
          if (got.used_count !== want.used_count) begin
            $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
            fail_count++;
          end
        end
      end

      // Predict the reply of each accepted request
      if (start && !busy)
        alloc_replies.push_back(compute_alloc_reply(in_req_type, in_segment, in_block,
                                                    in_in_use));
    end
    replies_due = alloc_replies.size();
  end

endmodule

// File: verif/tb_log_segment_free_block_allocator_unit.sv
`timescale 1ns / 1ps

module tb_log_segment_free_block_allocator_unit;
  import lsfba_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 115;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [SEG_W-1:0]     in_segment = '0;
  logic [BLK_W-1:0]     in_block = '0;
  logic                 in_in_use = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_accepted;
  logic [SEG_W-1:0]     out_next_segment;
  logic [BLK_W-1:0]     out_next_block;
  logic                 out_full_res;
  logic [CNT_W-1:0]     out_used_count;
  logic                 cfg_ready;
  int                   check_fails;
  int                   replies_due;
  int                   idle_pct = 0;
  int                   requests_sent = 0;
  int                   quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  log_segment_free_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_segment(in_segment), .in_block(in_block),
    .in_in_use(in_in_use), .out_valid(out_valid), .out_accepted(out_accepted),
    .out_next_segment(out_next_segment), .out_next_block(out_next_block),
    .out_full_res(out_full_res), .out_used_count(out_used_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  log_segment_free_block_allocator_checker alloc_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_segment(in_segment), .in_block(in_block),
    .in_in_use(in_in_use), .out_valid(out_valid), .out_accepted(out_accepted),
    .out_next_segment(out_next_segment), .out_next_block(out_next_block),
    .out_full_res(out_full_res), .out_used_count(out_used_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(check_fails), .replies_due(replies_due)
  );

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one request, idling first at random, and hold it until taken
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [SEG_W-1:0] seg,
                               input logic [BLK_W-1:0] blk, input logic mark);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_segment  <= seg;
    in_block    <= blk;
    in_in_use   <= mark;
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests_sent++;
  endtask

  // Drop start and wait until every reply has come back
  task automatic drain_requests();
    start <= 1'b0;
    while (replies_due != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Mostly stay inside the configured log, sometimes anywhere
  function automatic logic [SEG_W-1:0] pick_segment(int esc);
    if (esc < 2 || $urandom_range(99) < 15)
      return SEG_W'($urandom_range(63));
    return SEG_W'($urandom_range(esc - 1));
  endfunction

  function automatic logic [BLK_W-1:0] pick_block(int ebps);
    if (ebps < 1 || $urandom_range(99) < 15)
      return BLK_W'($urandom_range(63));
    return BLK_W'($urandom_range(ebps - 1));
  endfunction

  initial begin
    int               bps;
    int               segs;
    int               summ;
    int               ebps;
    int               esc;
    int               phase_base;
    int               roll;
    int               inuse_bias;
    logic [SEG_W-1:0] seg;
    logic [BLK_W-1:0] blk_end;
    logic             mark;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph < 4) ? 15 : (ph < 8) ? 56 : 0;
      case (ph)
        0:  begin bps = 64;  segs = 64;  summ = 1;  end
        1:  begin bps = 2;   segs = 2;   summ = 1;  end
        2:  begin bps = 4;   segs = 3;   summ = 1;  end
        3:  begin bps = 8;   segs = 4;   summ = 2;  end
        4:  begin bps = 127; segs = 127; summ = 63; end
        5:  begin bps = 0;   segs = 0;   summ = 0;  end
        6:  begin bps = 1;   segs = 1;   summ = 0;  end
        7:  begin bps = 16;  segs = 8;   summ = 15; end
        8:  begin bps = 6;   segs = 5;   summ = 6;  end
        9:  begin bps = 64;  segs = 64;  summ = 63; end
        10: begin
          bps  = $urandom_range(10, 2);
          segs = $urandom_range(6, 2);
          summ = $urandom_range(bps);
        end
        default: begin
          bps  = $urandom_range(127);
          segs = $urandom_range(127);
          summ = $urandom_range(63);
        end
      endcase
      ebps       = (bps > 64) ? 64 : bps;
      esc        = (segs > 64) ? 64 : segs;
      inuse_bias = (ph % 2 == 0) ? 60 : 80;

      // Reprogram while idle; the spare index must leave everything alone
      write_reg(CFG_BPS, CFG_DAT_W'(bps));
      write_reg(CFG_SEGCNT, CFG_DAT_W'(segs));
      write_reg(CFG_SUMMARY, CFG_DAT_W'(summ));
      if (ph % 3 == 2)
        write_reg(CFG_SPARE, CFG_DAT_W'($urandom_range(127)));
      cfg_valid <= 1'b0;
      phase_base = requests_sent;

      // Directed corners on the reset geometry
      if (ph == 0) begin
        issue_request(REQ_COUNT, 6'd0, 6'd0, USAGE_FREE);
        issue_request(REQ_SET, 6'd0, 6'd5, USAGE_INUSE);
        issue_request(REQ_SET, 6'd63, 6'd63, USAGE_INUSE);
        issue_request(REQ_SET, 6'd1, 6'd0, USAGE_INUSE);
        issue_request(REQ_SET, 6'd2, 6'd1, USAGE_INUSE);
        issue_request(REQ_COUNT, 6'd63, 6'd63, USAGE_INUSE);
        issue_request(REQ_NEXT, 6'd0, 6'd3, USAGE_FREE);
        issue_request(REQ_NEXT, 6'd1, 6'd63, USAGE_FREE);
        issue_request(REQ_NEXT, 6'd63, 6'd63, USAGE_INUSE);
        issue_request(REQ_NEXT, 6'd5, 6'd62, USAGE_FREE);
        issue_request(REQ_NEXT, 6'd0, 6'd63, USAGE_FREE);
        issue_request(REQ_SET, 6'd2, 6'd1, USAGE_FREE);
        issue_request(REQ_SET, 6'd63, 6'd0, USAGE_FREE);
        issue_request(REQ_UNKNOWN, 6'd63, 6'd63, USAGE_INUSE);
        issue_request(REQ_UNKNOWN, 6'd0, 6'd0, USAGE_FREE);
        issue_request(REQ_COUNT, 6'd0, 6'd0, USAGE_FREE);
      end

      // Random traffic with runs that fill or empty up to 12 blocks of one segment
      while (requests_sent - phase_base < ITEMS_PER_PHASE) begin
        roll    = $urandom_range(99);
        blk_end = (ebps > 0) ? BLK_W'(ebps - 1) : BLK_W'($urandom_range(63));
        if (roll < 10) begin
          seg  = pick_segment(esc);
          mark = (roll < 6) ? USAGE_INUSE : USAGE_FREE;
          for (int b = summ; b < ebps && b < summ + 12; b++)
            issue_request(REQ_SET, seg, BLK_W'(b), mark);
          issue_request(REQ_NEXT, pick_segment(esc), blk_end, 1'($urandom_range(1)));
        end else if (roll < 55) begin
          issue_request(REQ_SET, pick_segment(esc), pick_block(ebps),
                        ($urandom_range(99) < inuse_bias) ? USAGE_INUSE : USAGE_FREE);
        end else if (roll < 80) begin
          issue_request(REQ_NEXT, pick_segment(esc),
                        $urandom_range(1) ? blk_end : pick_block(ebps), 1'($urandom_range(1)));
        end else if (roll < 95) begin
          issue_request(REQ_COUNT, SEG_W'($urandom_range(63)), BLK_W'($urandom_range(63)),
                        1'($urandom_range(1)));
        end else begin
          issue_request(REQ_UNKNOWN, SEG_W'($urandom_range(63)), BLK_W'($urandom_range(63)),
                        1'($urandom_range(1)));
        end
      end
      drain_requests();
    end

    // Let any stray reply show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (check_fails == 0 && replies_due == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
